@@ rtl/core/ssid_pkg.sv @@
// shared types, sizes and codes for the sorted set block
package ssid_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 3;
  localparam int ECNT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_LISTED    = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_LIST
  } fsm_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  value;
  } cell_ctl_t;

  // what the chain reports back to the controller
  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  head;
  } chain_stat_t;

  // count masked to the result field width
  function automatic logic [ECNT_W-1:0] fit_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+ECNT_W-1:0] w;
    w = {{ECNT_W{1'b0}}, c};
    return w[ECNT_W-1:0];
  endfunction

endpackage

@@ rtl/core/ssid_if.sv @@
// item channels for the sorted set block
interface ssid_in_if import ssid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface ssid_out_if import ssid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [VAL_W-1:0]  entry_value;
  logic [ECNT_W-1:0]        entry_count;
  logic                     last;

  modport source (output valid, status, entry_value, entry_count, last, input ready);
  modport sink (input valid, status, entry_value, entry_count, last, output ready);
endinterface

@@ rtl/core/sorted_set_insert_delete.sv @@
// sorted set of distinct signed values with insert, remove and list items
//
// in_ch carries items: kind (insert, remove, list, or an unused code that is
// dropped without a result) and a signed 32-bit value. out_ch carries results:
// status, entry_value, entry_count and last. both use valid/ready.
// in insert and remove every cell compares its entry with the value at once
// and the row shifts by one place in the cycle the item is taken, so a new
// item is taken each cycle while the output register is free; the result is
// registered and shows in the cycle after the item is taken.
// a list item walks the stored values out of the head cell, rotating the
// occupied cells once per result, so it gives one result per stored value
// (up to DEPTH); no item is taken meanwhile. an empty set lists as a
// single empty result.
// reset clears the count and the output valid; cell contents are left as is
// and are never read before being written. when out_ch.ready is low the
// result register holds and in_ch.ready drops until it is taken.
module sorted_set_insert_delete import ssid_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  ssid_in_if.sink    in_ch,
  ssid_out_if.source out_ch
);

  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [ECNT_W-1:0] ecnt_r, ecnt_nxt;
  logic              last_r, last_nxt;

  cell_ctl_t         ctl;
  chain_stat_t       stat;
  logic              slot_free;
  logic              accept;
  kind_t             kind;

  assign kind      = kind_t'(in_ch.kind);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == FSM_IDLE) && slot_free;
  assign accept    = in_ch.valid && in_ch.ready;

  ssid_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count_r),
    .stat  (stat)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (accept && kind == KIND_LIST && count_r != '0) begin
          state_nxt = FSM_LIST;
        end
      end
      FSM_LIST: begin
        if (slot_free && remain_r == CNT_W'(1)) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.op        = CELL_HOLD;
    ctl.value     = in_ch.value;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    value_nxt     = value_r;
    ecnt_nxt      = ecnt_r;
    last_nxt      = last_r;
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          value_nxt = in_ch.value;
          last_nxt  = 1'b1;
          case (kind)
            KIND_INSERT: begin
              out_valid_nxt = 1'b1;
              if (stat.hit) begin
                status_nxt = ST_DUPLICATE;
              end else if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.op     = CELL_INSERT;
                count_nxt  = count_r + CNT_W'(1);
                status_nxt = ST_INSERTED;
              end
            end
            KIND_REMOVE: begin
              out_valid_nxt = 1'b1;
              if (stat.hit) begin
                ctl.op     = CELL_REMOVE;
                count_nxt  = count_r - CNT_W'(1);
                status_nxt = ST_REMOVED;
              end else begin
                status_nxt = ST_ABSENT;
              end
            end
            KIND_LIST: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_EMPTY;
              end else begin
                remain_nxt = count_r;
              end
            end
            default: begin
              out_valid_nxt = out_valid_r && !out_ch.ready;
            end
          endcase
          ecnt_nxt = fit_count(count_nxt);
        end
      end
      FSM_LIST: begin
        if (slot_free) begin
          ctl.op        = CELL_ROTATE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_LISTED;
          value_nxt     = stat.head;
          ecnt_nxt      = fit_count(count_r);
          last_nxt      = (remain_r == CNT_W'(1));
          remain_nxt    = remain_r - CNT_W'(1);
        end
      end
      default: begin
        ctl.op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    value_r  <= value_nxt;
    ecnt_r   <= ecnt_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_value = value_r;
  assign out_ch.entry_count = ecnt_r;
  assign out_ch.last        = last_r;

endmodule

@@ rtl/core/ssid_cell.sv @@
// one storage cell of the sorted chain
module ssid_cell import ssid_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              occ,
  input  logic              tail,
  input  logic              left_below,
  input  logic [VAL_W-1:0]  left_entry,
  input  logic [VAL_W-1:0]  right_entry,
  input  logic [VAL_W-1:0]  head_entry,
  output logic [VAL_W-1:0]  entry,
  output logic              below,
  output logic              eq
);

  logic [VAL_W-1:0] entry_r;
  logic [VAL_W-1:0] entry_nxt;

  assign entry = entry_r;
  assign below = occ && ($signed(entry_r) < $signed(ctl.value));
  assign eq    = occ && (entry_r == ctl.value);

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      CELL_INSERT: begin
        // cells at or above the slot move up by one
        if (!below) begin
          entry_nxt = left_below ? ctl.value : left_entry;
        end
      end
      CELL_REMOVE: begin
        if (!below) begin
          entry_nxt = right_entry;
        end
      end
      CELL_ROTATE: begin
        // ring over the occupied cells only
        entry_nxt = tail ? head_entry : right_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/core/ssid_chain.sv @@
// row of cells holding the set in ascending order
module ssid_chain import ssid_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]  count,
  output chain_stat_t       stat
);

  logic [VAL_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0] below;
  logic [DEPTH-1:0] eq;
  logic [DEPTH:0]   occ;

  assign occ[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              lb;
    logic [VAL_W-1:0]  le;
    logic [VAL_W-1:0]  re;

    assign occ[i] = count > CNT_W'(i);

    if (i == 0) begin : g_first
      // nothing sits left of the head, so it is the slot when not below
      assign lb = 1'b1;
      assign le = entry[i];
    end else begin : g_mid
      assign lb = below[i-1];
      assign le = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign re = entry[i];
    end else begin : g_inner
      assign re = entry[i+1];
    end

    ssid_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .tail        (occ[i] && !occ[i+1]),
      .left_below  (lb),
      .left_entry  (le),
      .right_entry (re),
      .head_entry  (entry[0]),
      .entry       (entry[i]),
      .below       (below[i]),
      .eq          (eq[i])
    );
  end

  assign stat.hit  = |eq;
  assign stat.head = entry[0];

endmodule

@@ rtl/core/ssid_checker.sv @@
// port-level checks for the sorted set block, bound to the top level
module ssid_checker import ssid_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [KIND_W-1:0]  in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [STAT_W-1:0]  out_status,
  input logic [ECNT_W-1:0]  out_entry_count,
  input logic               out_last
);

  localparam logic [CNT_W+ECNT_W-1:0] DEPTH_WIDE = (CNT_W+ECNT_W)'(DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (kind_t'(in_kind) == KIND_INSERT ||
    kind_t'(in_kind) == KIND_REMOVE) |=> out_valid && out_last)
    else $error("insert or remove gave no final result");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_t'(out_status) == ST_EMPTY |-> out_entry_count == '0 && out_last)
    else $error("empty result with nonzero count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_t'(out_status) == ST_FULL |->
    out_entry_count == DEPTH_WIDE[ECNT_W-1:0])
    else $error("full result with wrong count");

endmodule

bind sorted_set_insert_delete ssid_checker u_ssid_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_entry_count (out_ch.entry_count),
  .out_last        (out_ch.last)
);

@@ sim/ssid_result_check.sv @@
`timescale 1ns / 1ps
// result checker for the sorted set block: tracks the set and compares every result
module ssid_result_check import ssid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ssid_in_if   in_mon,
  ssid_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  value;
    logic [ECNT_W-1:0]        count;
    logic                     last;
  } set_result_t;

  logic signed [VAL_W-1:0] set_vals [DEPTH];
  int set_size;
  set_result_t expected_results[$];

  function automatic void note_result(status_t s, logic signed [VAL_W-1:0] v, logic l);
    set_result_t r;
    r.status = s;
    r.value = v;
    r.count = set_size[ECNT_W-1:0];
    r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic void apply_set_item(kind_t k, logic signed [VAL_W-1:0] v);
    int pos;
    logic hit;
    pos = 0;
    while (pos < set_size && set_vals[pos] < v) pos++;
    hit = (pos < set_size) && (set_vals[pos] == v);
    case (k)
      KIND_INSERT: begin
        if (hit) begin
          note_result(ST_DUPLICATE, v, 1'b1);
        end else if (set_size >= DEPTH) begin
          note_result(ST_FULL, v, 1'b1);
        end else begin
          for (int i = set_size; i > pos; i--) set_vals[i] = set_vals[i-1];
          set_vals[pos] = v;
          set_size++;
          note_result(ST_INSERTED, v, 1'b1);
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          for (int i = pos; i < set_size - 1; i++) set_vals[i] = set_vals[i+1];
          set_size--;
          note_result(ST_REMOVED, v, 1'b1);
        end else begin
          note_result(ST_ABSENT, v, 1'b1);
        end
      end
      KIND_LIST: begin
        if (set_size == 0) begin
          note_result(ST_EMPTY, v, 1'b1);
        end else begin
          for (int i = 0; i < set_size; i++)
            note_result(ST_LISTED, set_vals[i], i == set_size - 1);
        end
      end
      default: ;  // unused code gives no result
    endcase
  endfunction

  always @(posedge clk) begin : watch
    set_result_t exp_r;
    if (!rst_n) begin
      set_size = 0;
      expected_results.delete();
    end else begin
      // results first: an item taken at this edge cannot have caused one yet
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result status %0d value %0d count %0d last %0b",
                   $time, out_mon.status, out_mon.entry_value, out_mon.entry_count,
                   out_mon.last);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_mon.status !== exp_r.status || out_mon.entry_value !== exp_r.value ||
              out_mon.entry_count !== exp_r.count || out_mon.last !== exp_r.last) begin
            fail_count++;
            $display("%0t: mismatch exp {%0d %0d %0d %0b} got {%0d %0d %0d %0b}",
                     $time, exp_r.status, exp_r.value, exp_r.count, exp_r.last,
                     out_mon.status, out_mon.entry_value, out_mon.entry_count,
                     out_mon.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        apply_set_item(kind_t'(in_mon.kind), in_mon.value);
    end
    pending = expected_results.size();
  end

endmodule

@@ sim/sorted_set_insert_delete_test.sv @@
`timescale 1ns / 1ps
// top of the sorted set test: clock, reset, item traffic, output stalls and verdict
module sorted_set_insert_delete_test;
  import ssid_pkg::*;

  localparam int RANDOM_ITEMS = 256;
  localparam int SQUEEZE_ITEMS = 30;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_MIXED} mix_t;

  logic clk;
  logic rst_n;
  logic sender_calm;
  logic squeeze_req;
  int fail_count, pending, checked;
  int n_insert, n_remove, n_list, n_unused;

  ssid_in_if  in_ch();
  ssid_out_if out_ch();

  sorted_set_insert_delete uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  ssid_result_check result_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_mon(in_ch),
    .out_mon(out_ch),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // a narrow pool so that duplicates and hits are common
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      s = $urandom_range(0, 23);
      return s - 12;
    end
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        3: return VAL_MAX - 1;
        4: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic kind_t pick_kind(mix_t m);
    int r, ins, rem;
    r = $urandom_range(0, 99);
    case (m)
      MIX_FILL: begin
        ins = 80;
        rem = 90;
      end
      MIX_DRAIN: begin
        ins = 15;
        rem = 87;
      end
      default: begin
        ins = 40;
        rem = 80;
      end
    endcase
    if (r < ins) return KIND_INSERT;
    if (r < rem) return KIND_REMOVE;
    if (r < 97) return KIND_LIST;
    return KIND_IGNORE;
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(kind_t k, logic signed [VAL_W-1:0] v);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    case (k)
      KIND_INSERT: n_insert++;
      KIND_REMOVE: n_remove++;
      KIND_LIST: n_list++;
      default: n_unused++;
    endcase
  endtask

  initial begin : stimulus
    int sent;
    int run_len;
    mix_t mix;
    kind_t k;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_INSERT;
    in_ch.value = '0;
    sender_calm = 1'b0;
    squeeze_req = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store, ordering at both ends, duplicates, absent removes
    send_item(KIND_LIST, VAL_MIN);
    send_item(KIND_REMOVE, 7);
    send_item(KIND_INSERT, 5);
    send_item(KIND_INSERT, -3);
    send_item(KIND_INSERT, 5);
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_INSERT, 0);
    send_item(KIND_INSERT, -1);
    send_item(KIND_LIST, 0);
    send_item(KIND_IGNORE, 123);
    send_item(KIND_REMOVE, 0);
    send_item(KIND_REMOVE, VAL_MIN);
    send_item(KIND_REMOVE, VAL_MAX);
    send_item(KIND_REMOVE, 0);
    send_item(KIND_INSERT, 32'sh5555_5555);
    send_item(KIND_INSERT, 32'shAAAA_AAAA);
    send_item(KIND_LIST, VAL_MAX);
    send_item(KIND_REMOVE, -3);
    send_item(KIND_REMOVE, -1);
    send_item(KIND_REMOVE, 5);
    send_item(KIND_REMOVE, 32'sh5555_5555);
    send_item(KIND_REMOVE, 32'shAAAA_AAAA);
    send_item(KIND_LIST, VAL_MAX);

    // output side holds off while items keep coming, so the block backs up
    squeeze_req = 1'b1;
    sender_calm = 1'b1;
    sent = 0;
    repeat (SQUEEZE_ITEMS) begin
      k = pick_kind(MIX_FILL);
      send_item(k, pick_value());
      if (k != KIND_IGNORE) sent++;
    end

    while (sent < RANDOM_ITEMS) begin
      mix = mix_t'($urandom_range(0, 2));
      sender_calm = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(20, 45);
      repeat (run_len) begin
        k = pick_kind(mix);
        send_item(k, pick_value());
        if (k != KIND_IGNORE) sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("sent %0d inserts, %0d removes, %0d lists and %0d unused-code items",
             n_insert, n_remove, n_list, n_unused);
    $display("compared %0d results against the tracked set contents", checked);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    int calm;
    logic squeezed;
    out_ch.ready = 1'b0;
    stall = 0;
    calm = 0;
    squeezed = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
        squeezed = 1'b1;
      end else if (calm > 0) begin
        out_ch.ready <= 1'b1;
        calm--;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(30, 120);
        else stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
